// ===== design/calds_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, handshake structs and calendar helpers for the date keeper.
// No dependencies; imported by every module of the block.
package calds_pkg;

  localparam int DEFAULT_AMOUNT_WIDTH = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_SUB  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_BAD_LOAD = 2'd2;

  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] RESET_YEAR = 14'd2018;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST    = 5'd1;
  localparam logic [4:0] LONG_LEN     = 5'd31;
  localparam logic [4:0] SHORT_LEN    = 5'd30;
  localparam logic [4:0] FEB_LEN      = 5'd28;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  // ceil(2^17 / 25): floor(y * DIV25_RECIP / 2^17) == y / 25 for any 14-bit y
  localparam logic [26:0] DIV25_RECIP = 27'd5243;

  typedef struct packed {
    logic accept;  // latch the incoming request
    logic setup;   // seed the day accumulator, check a load
    logic step;    // walk one month
    logic finish;  // commit the date and fill the output register
  } calds_cmd_t;

  typedef struct packed {
    logic done;      // walk complete
    logic out_free;  // output register can take a result this cycle
  } calds_sts_t;

  // Divisible by 4 and not by 100, or divisible by 400.
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [9:0]  q;
    logic [13:0] q25;
    logic        div25;
    prod  = {13'd0, y} * DIV25_RECIP;
    q     = prod[26:17];
    q25   = {q, 4'b0000} + {1'b0, q, 3'b000} + {4'b0000, q};
    div25 = (q25 == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Zero for a month code outside 1..12.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LONG_LEN;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = SHORT_LEN;
      4'd2:                                       len = leap ? FEB_LEAP_LEN : FEB_LEN;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/calds_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the date keeper: sequences accept, setup, month walk and commit.
// Depends on calds_pkg for the command and status structs.
module calds_ctrl
  import calds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  calds_sts_t sts,
  output calds_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SETUP  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the previous result has been taken
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/calds_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the date keeper: request latch, current date, day accumulator,
// month-length unit and output register. Depends on calds_pkg.
module calds_dp
  import calds_pkg::*;
#(
  parameter int AMOUNT_WIDTH = DEFAULT_AMOUNT_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_command,
  input  logic [AMOUNT_WIDTH-1:0] in_amount_days,
  input  logic [13:0]             in_load_year,
  input  logic [3:0]              in_load_month,
  input  logic [4:0]              in_load_day,
  input  calds_cmd_t              cmd,
  output calds_sts_t              sts,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [13:0]             out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day,
  output logic [1:0]              out_status
);

  // signed accumulator: day + amount on the way up, day - amount on the way down
  localparam int DW = AMOUNT_WIDTH + 2;

  logic [1:0]              req_cmd_r;
  logic [AMOUNT_WIDTH-1:0] req_amt_r;
  logic [13:0]             req_year_r;
  logic [3:0]              req_month_r;
  logic [4:0]              req_day_r;

  logic [13:0] cur_year_r, cur_year_nxt;
  logic [3:0]  cur_month_r, cur_month_nxt;
  logic [4:0]  cur_day_r, cur_day_nxt;

  logic signed [DW-1:0] acc_r, acc_nxt;
  logic                 sat_r, sat_nxt;
  logic                 load_ok_r, load_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [13:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic                 is_add, is_sub;
  logic [13:0]          len_year;
  logic [3:0]           len_month;
  logic [4:0]           mlen;
  logic signed [DW-1:0] mlen_s, day_s, amt_s, dec_len_s;
  logic [4:0]           fin_day;

  assign is_add = (req_cmd_r == CMD_ADD);
  assign is_sub = (req_cmd_r == CMD_SUB);

  // one month-length unit: the load date during setup, otherwise the month
  // being left (add) or the month being entered (subtract)
  always_comb begin
    if (cmd.setup) begin
      len_year  = req_year_r;
      len_month = req_month_r;
    end else begin
      len_year  = cur_year_r;
      len_month = is_sub ? (cur_month_r - 4'd1) : cur_month_r;
    end
  end

  assign mlen      = month_len(is_leap(len_year), len_month);
  assign mlen_s    = $signed({{(DW-5){1'b0}}, mlen});
  assign day_s     = $signed({{(DW-5){1'b0}}, cur_day_r});
  assign amt_s     = $signed({2'b00, req_amt_r});
  assign dec_len_s = $signed({{(DW-5){1'b0}}, LONG_LEN});

  assign sts.done = sat_r || (!is_add && !is_sub) ||
                    (is_add && (acc_r <= mlen_s)) ||
                    (is_sub && !acc_r[DW-1] && (acc_r != '0));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign fin_day = (is_add || is_sub) ? acc_r[4:0] : cur_day_r;

  always_comb begin
    cur_year_nxt   = cur_year_r;
    cur_month_nxt  = cur_month_r;
    cur_day_nxt    = cur_day_r;
    acc_nxt        = acc_r;
    sat_nxt        = sat_r;
    load_ok_nxt    = load_ok_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_year_nxt   = out_year_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_status_nxt = out_status_r;

    if (cmd.setup) begin
      sat_nxt     = 1'b0;
      acc_nxt     = is_add ? (day_s + amt_s) : (day_s - amt_s);
      // a month outside 1..12 gives length zero and fails the day check
      load_ok_nxt = (req_year_r >= YEAR_MIN) && (req_year_r <= YEAR_MAX) &&
                    (req_day_r != 5'd0) && (req_day_r <= mlen);
    end

    if (cmd.step && is_add) begin
      acc_nxt = acc_r - mlen_s;
      if (cur_month_r == MONTH_DEC) begin
        if (cur_year_r == YEAR_MAX) begin
          // clamp at the last representable date
          sat_nxt       = 1'b1;
          cur_month_nxt = MONTH_DEC;
          acc_nxt       = dec_len_s;
        end else begin
          cur_month_nxt = MONTH_JAN;
          cur_year_nxt  = cur_year_r + 14'd1;
        end
      end else begin
        cur_month_nxt = cur_month_r + 4'd1;
      end
    end

    if (cmd.step && is_sub) begin
      if (cur_month_r == MONTH_JAN) begin
        if (cur_year_r == YEAR_MIN) begin
          // clamp at the first representable date
          sat_nxt = 1'b1;
          acc_nxt = $signed({{(DW-5){1'b0}}, DAY_FIRST});
        end else begin
          cur_year_nxt  = cur_year_r - 14'd1;
          cur_month_nxt = MONTH_DEC;
          acc_nxt       = acc_r + dec_len_s;
        end
      end else begin
        cur_month_nxt = cur_month_r - 4'd1;
        acc_nxt       = acc_r + mlen_s;
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (req_cmd_r == CMD_LOAD) begin
        if (load_ok_r) begin
          cur_year_nxt   = req_year_r;
          cur_month_nxt  = req_month_r;
          cur_day_nxt    = req_day_r;
          out_year_nxt   = req_year_r;
          out_month_nxt  = req_month_r;
          out_day_nxt    = req_day_r;
          out_status_nxt = STATUS_OK;
        end else begin
          out_year_nxt   = cur_year_r;
          out_month_nxt  = cur_month_r;
          out_day_nxt    = cur_day_r;
          out_status_nxt = STATUS_BAD_LOAD;
        end
      end else begin
        cur_day_nxt    = fin_day;
        out_year_nxt   = cur_year_r;
        out_month_nxt  = cur_month_r;
        out_day_nxt    = fin_day;
        out_status_nxt = sat_r ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd_r   <= in_command;
      req_amt_r   <= in_amount_days;
      req_year_r  <= in_load_year;
      req_month_r <= in_load_month;
      req_day_r   <= in_load_day;
    end
    acc_r        <= acc_nxt;
    sat_r        <= sat_nxt;
    load_ok_r    <= load_ok_nxt;
    out_year_r   <= out_year_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= RESET_YEAR;
      cur_month_r <= MONTH_JAN;
      cur_day_r   <= DAY_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      cur_year_r  <= cur_year_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_year   = out_year_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_status = out_status_r;

endmodule

// ===== design/calendar_date_add_subtract_days.sv =====
`timescale 1ns / 1ps
// Gregorian date keeper: load a date, add or subtract a day count, one month per cycle.
// Sequence per request: accept, setup, month walk, commit to the output register; the walk
// crosses up to about 2150 months for a 16-bit amount, and load and unused commands take no walk steps.
// A new request is taken only once the previous one has been committed (in_stall meanwhile).
// Reset (synchronous, rst_n low): date 2018-01-01, controller idle, no result pending.
module calendar_date_add_subtract_days
  import calds_pkg::*;
#(
  parameter int AMOUNT_WIDTH = DEFAULT_AMOUNT_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [AMOUNT_WIDTH-1:0] in_amount_days,
  input  logic [13:0]             in_load_year,
  input  logic [3:0]              in_load_month,
  input  logic [4:0]              in_load_day,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [13:0]             out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day,
  output logic [1:0]              out_status
);

  calds_cmd_t cmd;
  calds_sts_t sts;

  calds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  calds_dp #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_amount_days (in_amount_days),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_status     (out_status)
  );

endmodule

// ===== design/calds_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the date keeper, bound to the top level.
// Depends on calds_pkg for the year limits and status codes.
module calds_checker
  import calds_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [1:0]  out_status
);

  // an accepted request keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a request");

  // a new result only appears while a request is in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= YEAR_MIN) && (out_year <= YEAR_MAX) &&
                  (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) &&
                  (out_day >= DAY_FIRST) && (out_day <= LONG_LEN))
    else $error("result date out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_SAT) ||
                  (out_status == STATUS_BAD_LOAD))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year) && $stable(out_month) &&
                               $stable(out_day) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind calendar_date_add_subtract_days calds_checker u_calds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_year   (out_year),
  .out_month  (out_month),
  .out_day    (out_day),
  .out_status (out_status)
);
